// ----- src/meu_pkg.sv -----
// Shared types for the modular inverse unit.
package meu_pkg;

  // Status reported by the iterative divide/multiply unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/modular_inverse_euclid_unit.sv -----
// Modular inverse by the extended Euclidean iteration, top level.
//
// Pulse start with in_value and in_modulus while busy is low; the pair is
// taken at that edge and busy rises. Each Euclid round runs one bit-serial
// division in the shared divide/multiply unit; when in_value is zero no
// round runs and the result strobe follows the first check. out_inverse is
// valid for the single cycle in which out_valid is high and must be captured
// then; busy falls in that same cycle, so the next start may coincide with
// the strobe. Inputs are assumed coprime; for other pairs the same iteration
// runs and its result is given.
module modular_inverse_euclid_unit #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] in_value,
  input  logic [OPERAND_BITS-1:0] in_modulus,
  output logic                    out_valid,
  output logic [OPERAND_BITS-1:0] out_inverse
);

  localparam int W = OPERAND_BITS;
  localparam int C = OPERAND_BITS + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] m_r, m_nxt;
  logic [C-1:0] lastx_r, lastx_nxt;
  logic [C-1:0] x_r, x_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_inv_r, out_inv_nxt;
  logic         div_start;
  logic [W-1:0] div_rem;
  logic [C-1:0] div_prod;
  logic [C-1:0] fix_sum;
  meu_pkg::div_stat_t div_stat;

  meu_divmul #(.W(W)) u_divmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (a_r),
    .divisor   (b_r),
    .mcand     (x_r),
    .remainder (div_rem),
    .product   (div_prod),
    .stat      (div_stat)
  );

  assign fix_sum = lastx_r + {1'b0, m_r};

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    lastx_nxt     = lastx_r;
    x_nxt         = x_r;
    out_valid_nxt = 1'b0;
    out_inv_nxt   = out_inv_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt     = in_modulus;
          b_nxt     = in_value;
          m_nxt     = in_modulus;
          lastx_nxt = '0;
          x_nxt     = C'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (b_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // Advance the remainder and coefficient pairs once the quotient is in.
        if (div_stat.done) begin
          a_nxt     = b_r;
          b_nxt     = div_rem;
          lastx_nxt = x_r;
          x_nxt     = lastx_r - div_prod;
          state_nxt = ST_CHECK;
        end
      end
      ST_FIN: begin
        out_inv_nxt   = lastx_r[C-1] ? fix_sum[W-1:0] : lastx_r[W-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    m_r       <= m_nxt;
    lastx_r   <= lastx_nxt;
    x_r       <= x_nxt;
    out_inv_r <= out_inv_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_inverse = out_inv_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE)) else $error("result strobe outside idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV)) else $error("divider done outside divide state");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV)) else $error("divider running outside divide state");

endmodule

// ----- src/meu_divmul.sv -----
// Bit-serial restoring divider that forms quotient times a multiplicand as it goes.
module meu_divmul #(
  parameter int W = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  input  logic [W:0]           mcand,
  output logic [W-1:0]         remainder,
  output logic [W:0]           product,
  output meu_pkg::div_stat_t   stat
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [W:0]    mc_r, mc_nxt;
  logic [W:0]    prod_r, prod_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic          ge;

  // One quotient bit per cycle, MSB first.
  assign trial = {rem_r, dvd_r[W-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    mc_nxt   = mc_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      mc_nxt   = mcand;
      prod_nxt = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? W'(trial - {1'b0, div_r}) : trial[W-1:0];
      dvd_nxt  = {dvd_r[W-2:0], 1'b0};
      // Horner accumulation of q*x, wrapping at the coefficient width.
      prod_nxt = {prod_r[W-1:0], 1'b0} + (ge ? mc_r : '0);
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    div_r  <= div_nxt;
    mc_r   <= mc_nxt;
    prod_r <= prod_nxt;
  end

  assign remainder = rem_r;
  assign product   = prod_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still iterating");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r)) else $error("remainder not below divisor");

endmodule
